FILE: rtl/rgbled_pkg.sv
// ----------------------------------------------------------------------------
// rgbled_pkg
// Shared types, constants and color functions of the RGB status LED sequencer.
// ----------------------------------------------------------------------------
package rgbled_pkg;

    localparam int NOW_W  = 32;
    localparam int CHAN_W = 8;
    localparam int HUE_W  = 11;

    localparam logic [NOW_W-1:0]  BLINK_PERIOD_MS   = 32'd350;
    localparam logic [NOW_W-1:0]  RAINBOW_PERIOD_MS = 32'd18;
    localparam logic [HUE_W:0]    WHEEL_STEPS       = 12'd1536;
    localparam logic [HUE_W-1:0]  WHEEL_STRIDE      = 11'd4;
    localparam logic [CHAN_W-1:0] CHAN_FULL         = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_OFF          = 8'h00;

    // Hue wheel segments, 256 steps each
    localparam logic [2:0] SEG_RED_TO_YELLOW   = 3'd0;
    localparam logic [2:0] SEG_YELLOW_TO_GREEN = 3'd1;
    localparam logic [2:0] SEG_GREEN_TO_CYAN   = 3'd2;
    localparam logic [2:0] SEG_CYAN_TO_BLUE    = 3'd3;
    localparam logic [2:0] SEG_BLUE_TO_MAGENTA = 3'd4;
    localparam logic [2:0] SEG_MAGENTA_TO_RED  = 3'd5;

    // Register indexes (address bit 2)
    localparam logic REG_LED_MODE   = 1'b0;
    localparam logic REG_BRIGHTNESS = 1'b1;

    localparam logic [CHAN_W-1:0] BRIGHTNESS_RESET = 8'd255;

    typedef enum logic [1:0] {
        MODE_STEADY_RED  = 2'd0,
        MODE_BLINK_BLUE  = 2'd1,
        MODE_BLINK_GREEN = 2'd2,
        MODE_RAINBOW     = 2'd3
    } t_led_mode;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        t_led_mode         led_mode;
        logic [CHAN_W-1:0] brightness;
    } t_cfg;

    function automatic t_rgb hue_to_rgb(input logic [HUE_W-1:0] hue);
        t_rgb              c;
        logic [CHAN_W-1:0] ramp;
        ramp = hue[CHAN_W-1:0];
        c    = '0;
        case (hue[HUE_W-1:CHAN_W])
            SEG_RED_TO_YELLOW: begin
                c.red = CHAN_FULL; c.green = ramp;
            end
            SEG_YELLOW_TO_GREEN: begin
                c.red = ~ramp; c.green = CHAN_FULL;
            end
            SEG_GREEN_TO_CYAN: begin
                c.green = CHAN_FULL; c.blue = ramp;
            end
            SEG_CYAN_TO_BLUE: begin
                c.green = ~ramp; c.blue = CHAN_FULL;
            end
            SEG_BLUE_TO_MAGENTA: begin
                c.red = ramp; c.blue = CHAN_FULL;
            end
            SEG_MAGENTA_TO_RED: begin
                c.red = CHAN_FULL; c.blue = ~ramp;
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

    // floor(c * b / 255), exact for every product of two 8-bit values
    function automatic logic [CHAN_W-1:0] scale_chan(input logic [CHAN_W-1:0] c,
                                                     input logic [CHAN_W-1:0] b);
        logic [2*CHAN_W-1:0] prod;
        logic [2*CHAN_W:0]   sum;
        prod = c * b;
        sum  = {1'b0, prod} + {{(CHAN_W+1){1'b0}}, prod[2*CHAN_W-1:CHAN_W]} + 1'b1;
        return sum[2*CHAN_W-1:CHAN_W];
    endfunction

endpackage

FILE: rtl/rgbled_regs.sv
// ----------------------------------------------------------------------------
// rgbled_regs
// Configuration registers behind the APB-style port: mode and brightness.
// ----------------------------------------------------------------------------
module rgbled_regs import rgbled_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (paddr[2])
                REG_LED_MODE:   n_cfg.led_mode   = t_led_mode'(pwdata[1:0]);
                REG_BRIGHTNESS: n_cfg.brightness = pwdata[CHAN_W-1:0];
                default:        n_cfg            = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.led_mode   <= MODE_STEADY_RED;
            r_cfg.brightness <= BRIGHTNESS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LED_MODE:   prdata = {30'd0, r_cfg.led_mode};
            REG_BRIGHTNESS: prdata = {24'd0, r_cfg.brightness};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/rgbled_color.sv
// ----------------------------------------------------------------------------
// rgbled_color
// Sequencer state (stamps, blink phase, hue) and the unscaled color register.
// ----------------------------------------------------------------------------
module rgbled_color import rgbled_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  logic [NOW_W-1:0] i_now_ms,
    input  t_led_mode        i_led_mode,
    output t_rgb             o_rgb
);

    t_led_mode        r_last_mode;
    logic [NOW_W-1:0] r_blink_stamp;
    logic [NOW_W-1:0] r_rainbow_stamp;
    logic             r_blink_lit;
    logic [HUE_W-1:0] r_hue;
    t_rgb             r_rgb;

    logic [NOW_W-1:0] n_blink_stamp;
    logic [NOW_W-1:0] n_rainbow_stamp;
    logic             n_blink_lit;
    logic [HUE_W-1:0] n_hue;
    t_rgb             n_rgb;

    logic             changed;
    logic [NOW_W-1:0] base_blink;
    logic [NOW_W-1:0] base_rainbow;
    logic             base_lit;
    logic [HUE_W:0]   hue_sum;
    logic [HUE_W-1:0] hue_next;

    // A mode change restarts both timers and lights the blink phase
    assign changed      = (i_led_mode != r_last_mode);
    assign base_blink   = changed ? i_now_ms : r_blink_stamp;
    assign base_rainbow = changed ? i_now_ms : r_rainbow_stamp;
    assign base_lit     = changed ? 1'b1 : r_blink_lit;

    assign hue_sum  = {1'b0, r_hue} + {1'b0, WHEEL_STRIDE};
    assign hue_next = (hue_sum >= WHEEL_STEPS) ? HUE_W'(hue_sum - WHEEL_STEPS)
                                               : hue_sum[HUE_W-1:0];

    always_comb begin
        n_blink_stamp   = base_blink;
        n_rainbow_stamp = base_rainbow;
        n_blink_lit     = base_lit;
        n_hue           = r_hue;
        n_rgb           = '0;
        case (i_led_mode)
            MODE_STEADY_RED: begin
                n_rgb.red = CHAN_FULL;
            end
            MODE_BLINK_BLUE, MODE_BLINK_GREEN: begin
                if ((i_now_ms - base_blink) >= BLINK_PERIOD_MS) begin
                    n_blink_stamp = i_now_ms;
                    n_blink_lit   = ~base_lit;
                end
                if (i_led_mode == MODE_BLINK_BLUE) begin
                    n_rgb.blue = n_blink_lit ? CHAN_FULL : CHAN_OFF;
                end else begin
                    n_rgb.green = n_blink_lit ? CHAN_FULL : CHAN_OFF;
                end
            end
            MODE_RAINBOW: begin
                if ((i_now_ms - base_rainbow) >= RAINBOW_PERIOD_MS) begin
                    n_rainbow_stamp = i_now_ms;
                    n_hue           = hue_next;
                end
                n_rgb = hue_to_rgb(n_hue);
            end
            default: begin
                n_rgb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_mode     <= MODE_STEADY_RED;
            r_blink_stamp   <= '0;
            r_rainbow_stamp <= '0;
            r_blink_lit     <= 1'b0;
            r_hue           <= '0;
        end else if (i_load) begin
            r_last_mode     <= i_led_mode;
            r_blink_stamp   <= n_blink_stamp;
            r_rainbow_stamp <= n_rainbow_stamp;
            r_blink_lit     <= n_blink_lit;
            r_hue           <= n_hue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;

endmodule

FILE: rtl/rgbled_scale.sv
// ----------------------------------------------------------------------------
// rgbled_scale
// Brightness scaling of the three channels into the result register.
// ----------------------------------------------------------------------------
module rgbled_scale import rgbled_pkg::*; (
    input  logic              i_clk,
    input  logic              i_load,
    input  t_rgb              i_rgb,
    input  logic [CHAN_W-1:0] i_brightness,
    output t_rgb              o_rgb
);

    t_rgb r_rgb;
    t_rgb n_rgb;

    always_comb begin
        n_rgb.red   = scale_chan(i_rgb.red,   i_brightness);
        n_rgb.green = scale_chan(i_rgb.green, i_brightness);
        n_rgb.blue  = scale_chan(i_rgb.blue,  i_brightness);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rgb <= n_rgb;
        end
    end

    assign o_rgb = r_rgb;

endmodule

FILE: rtl/rgb_status_led_sequencer.sv
// ----------------------------------------------------------------------------
// rgb_status_led_sequencer
// Time-driven RGB status LED pattern generator with brightness scaling.
// ----------------------------------------------------------------------------
// Takes one time sample per cycle while the output is not stalled and
// returns one scaled RGB item per sample. Items pass an input register, a
// color stage that also updates the sequencer state (blink and rainbow
// timers, hue position), and a scaling stage that drives the output register.
// Back-pressure stalls all stages together; an empty stage still takes the
// next item, so the input stays ready while the output holds as long as
// the input or color stage is empty.
// Write led_mode and brightness only with no item in flight.
module rgb_status_led_sequencer import rgbled_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] now_ms
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg             cfg;
    logic [NOW_W-1:0] r_now;
    logic             r_in_valid;
    logic             r_col_valid;
    logic             r_out_valid;
    logic             adv_in;
    logic             adv_col;
    logic             adv_out;
    t_rgb             col_rgb;
    t_rgb             out_rgb;

    rgbled_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // A stage moves when it is empty or its contents move on
    assign adv_out = ~r_out_valid | m_axis_tready;
    assign adv_col = ~r_col_valid | adv_out;
    assign adv_in  = ~r_in_valid  | adv_col;

    assign s_axis_tready = adv_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_col_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_in) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv_col) begin
                r_col_valid <= r_in_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_col_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && s_axis_tvalid) begin
            r_now <= s_axis_tdata;
        end
    end

    rgbled_color u_color (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (r_in_valid & adv_col),
        .i_now_ms   (r_now),
        .i_led_mode (cfg.led_mode),
        .o_rgb      (col_rgb)
    );

    rgbled_scale u_scale (
        .i_clk        (i_clk),
        .i_load       (r_col_valid & adv_out),
        .i_rgb        (col_rgb),
        .i_brightness (cfg.brightness),
        .o_rgb        (out_rgb)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {out_rgb.blue, out_rgb.green, out_rgb.red};

endmodule

FILE: rtl/rgbled_checker.sv
// ----------------------------------------------------------------------------
// rgbled_checker
// Port-level checks of the RGB status LED sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module rgbled_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // Reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // With the output empty every stage can move, so the input must be ready
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // A stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output item changed");

    // Every pattern leaves at least one channel dark
    a_one_chan_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] == 8'd0) || (m_axis_tdata[15:8] == 8'd0)
                          || (m_axis_tdata[23:16] == 8'd0))
        else $error("all three channels lit");

endmodule

bind rgb_status_led_sequencer rgbled_checker u_checker (.*);
